// ----- rtl/core/biu_pkg.sv -----
// Shared types and constants for the bilinear image upscaler.
// Request and response word layouts, command and CSR codes, small helpers.
// No dependencies.
package biu_pkg;

   localparam int CHAN_W      = 8;
   localparam int PIXEL_W     = 32;
   localparam int SRC_COORD_W = 8;
   localparam int DCOORD_W    = 12;
   localparam int SIZE_W      = 9;
   localparam int STEP_W      = 17;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int COORD_EXT_W = 13;
   localparam int DST_LIM_W   = 17;

   typedef enum logic [0:0] {
      CMD_WRITE   = 1'b0,
      CMD_REQUEST = 1'b1
   } cmd_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_X        = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_Y        = 2'd3;

   localparam logic [SIZE_W-1:0] SOURCE_WIDTH_RESET  = 9'd256;
   localparam logic [SIZE_W-1:0] SOURCE_HEIGHT_RESET = 9'd256;
   localparam logic [STEP_W-1:0] STEP_RESET          = 17'd65536;

   typedef struct packed {
      cmd_type                cmd;
      logic [SRC_COORD_W-1:0] src_col;
      logic [SRC_COORD_W-1:0] src_row;
      logic [CHAN_W-1:0]      in_blue;
      logic [CHAN_W-1:0]      in_green;
      logic [CHAN_W-1:0]      in_red;
      logic [CHAN_W-1:0]      in_alpha;
      logic [DCOORD_W-1:0]    dst_col;
      logic [DCOORD_W-1:0]    dst_row;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   out_blue;
      logic [CHAN_W-1:0]   out_green;
      logic [CHAN_W-1:0]   out_red;
      logic [CHAN_W-1:0]   out_alpha;
      logic [DCOORD_W-1:0] out_col;
      logic [DCOORD_W-1:0] out_row;
   } rsp_word_type;

   // neighbor selection handed from the address stage to the blend stage
   typedef struct packed {
      logic x_par;
      logic y_par;
      logic x_clamp;
      logic y_clamp;
   } tap_sel_type;

   // width of a bank address half (coordinate divided by two)
   function automatic int half_width(input int depth);
      int w;
      w = $clog2(depth);
      return (w > 1) ? w - 1 : 1;
   endfunction

endpackage

// ----- rtl/core/bilinear_image_upscaler.sv -----
// Bilinear image upscaler top level: CSRs, pipeline valid chain, assertions.
// Uses biu_pkg, biu_coord, biu_frame and biu_blend.
//
// Channel  Dir  Handshake              Word
// req      in   req_valid / req_stall  biu_pkg::req_word_type
// rsp      out  rsp_valid / rsp_stall  biu_pkg::rsp_word_type
// csr      in   csr_wr_en              csr_index, csr_wdata
//
// One word accepted per clock while req_stall is low. A pixel request is answered
// after the position, frame read, horizontal blend and vertical blend registers.
// A pixel write lands in the frame the clock after acceptance; no response.
// The frame is four parity banks, so all four neighbors are read together.
// Reset clears valids, loads CSR defaults; frame stays undefined until written.
// A response stall holds the output register while bubbles behind it fill.
module bilinear_image_upscaler #(
   parameter int SRC_MAX_WIDTH  = 256,
   parameter int SRC_MAX_HEIGHT = 256,
   parameter int DST_MAX_DIM    = 4096,
   parameter int FRAC_BITS      = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  biu_pkg::req_word_type                  req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output biu_pkg::rsp_word_type                  rsp_word,
   input  logic                                   csr_wr_en,
   input  logic [biu_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [biu_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam int CH = biu_pkg::half_width(SRC_MAX_WIDTH);
   localparam int RH = biu_pkg::half_width(SRC_MAX_HEIGHT);

   logic [biu_pkg::SIZE_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [biu_pkg::STEP_W-1:0] step_x_ff, step_x_in, step_y_ff, step_y_in;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;
   logic take, leave1, load2, load3, load4;
   logic wr_en;

   logic                                 s1_write, s1_wr_ok;
   logic [1:0]                           wr_bank;
   logic [CH-1:0]                        wr_col, rd_col_even, rd_col_odd;
   logic [RH-1:0]                        wr_row, rd_row_even, rd_row_odd;
   logic [biu_pkg::PIXEL_W-1:0]          wr_data;
   logic [3:0][biu_pkg::PIXEL_W-1:0]     rd_data;
   logic [FRAC_BITS-1:0]                 frac_x, frac_y;
   biu_pkg::tap_sel_type                 tap_sel;
   logic [biu_pkg::DCOORD_W-1:0]         s1_col, s1_row;

   // CSR writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            biu_pkg::CSR_SOURCE_WIDTH:  width_in  = csr_wdata[biu_pkg::SIZE_W-1:0];
            biu_pkg::CSR_SOURCE_HEIGHT: height_in = csr_wdata[biu_pkg::SIZE_W-1:0];
            biu_pkg::CSR_STEP_X:        step_x_in = csr_wdata[biu_pkg::STEP_W-1:0];
            biu_pkg::CSR_STEP_Y:        step_y_in = csr_wdata[biu_pkg::STEP_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= biu_pkg::SOURCE_WIDTH_RESET;
         height_ff <= biu_pkg::SOURCE_HEIGHT_RESET;
         step_x_ff <= biu_pkg::STEP_RESET;
         step_y_ff <= biu_pkg::STEP_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         step_x_ff <= step_x_in;
         step_y_ff <= step_y_in;
      end
   end

   // valid chain; writes drop out after stage one
   always_comb begin
      rdy4   = !v4_ff || !rsp_stall;
      rdy3   = !v3_ff || rdy4;
      rdy2   = !v2_ff || rdy3;
      rdy1   = !v1_ff || s1_write || rdy2;
      take   = req_valid && rdy1;
      leave1 = v1_ff && (s1_write || rdy2);
      load2  = v1_ff && !s1_write && rdy2;
      load3  = v2_ff && rdy3;
      load4  = v3_ff && rdy4;
      wr_en  = v1_ff && s1_write && s1_wr_ok;
      v1_in  = take || (v1_ff && !leave1);
      v2_in  = load2 || (v2_ff && !load3);
      v3_in  = load3 || (v3_ff && !load4);
      v4_in  = load4 || (v4_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign req_stall = !rdy1;
   assign rsp_valid = v4_ff;

   biu_coord #(
      .SRC_MAX_WIDTH  (SRC_MAX_WIDTH),
      .SRC_MAX_HEIGHT (SRC_MAX_HEIGHT),
      .DST_MAX_DIM    (DST_MAX_DIM),
      .FRAC_BITS      (FRAC_BITS)
   ) u_coord (
      .clock         (clock),
      .load          (take),
      .req_word      (req_word),
      .source_width  (width_ff),
      .source_height (height_ff),
      .step_x        (step_x_ff),
      .step_y        (step_y_ff),
      .is_write      (s1_write),
      .wr_ok         (s1_wr_ok),
      .wr_bank       (wr_bank),
      .wr_col        (wr_col),
      .wr_row        (wr_row),
      .wr_data       (wr_data),
      .rd_col_even   (rd_col_even),
      .rd_col_odd    (rd_col_odd),
      .rd_row_even   (rd_row_even),
      .rd_row_odd    (rd_row_odd),
      .frac_x        (frac_x),
      .frac_y        (frac_y),
      .tap_sel       (tap_sel),
      .dst_col       (s1_col),
      .dst_row       (s1_row)
   );

   biu_frame #(
      .COL_HALF_W (CH),
      .ROW_HALF_W (RH)
   ) u_frame (
      .clock       (clock),
      .wr_en       (wr_en),
      .wr_bank     (wr_bank),
      .wr_col      (wr_col),
      .wr_row      (wr_row),
      .wr_data     (wr_data),
      .rd_en       (load2),
      .rd_col_even (rd_col_even),
      .rd_col_odd  (rd_col_odd),
      .rd_row_even (rd_row_even),
      .rd_row_odd  (rd_row_odd),
      .rd_data     (rd_data)
   );

   biu_blend #(
      .FRAC_BITS (FRAC_BITS)
   ) u_blend (
      .clock    (clock),
      .load2    (load2),
      .load3    (load3),
      .load4    (load4),
      .rd_data  (rd_data),
      .frac_x   (frac_x),
      .frac_y   (frac_y),
      .tap_sel  (tap_sel),
      .dst_col  (s1_col),
      .dst_row  (s1_row),
      .rsp_word (rsp_word)
   );

   // a frame write and a neighbor read never share a clock
   assert property (@(posedge clock) disable iff (reset) !(wr_en && load2))
      else $error("frame write and read in the same cycle");

   // input backpressure only comes from a request stuck in stage one
   assert property (@(posedge clock) disable iff (reset) req_stall |-> (v1_ff && !s1_write))
      else $error("req_stall without a blocked request in stage one");

   // pipeline comes out of reset empty
   assert property (@(posedge clock) reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

endmodule

// ----- rtl/core/biu_coord.sv -----
// Stage one of the upscaler: source position multiply and frame addressing.
// Uses biu_pkg; feeds biu_frame and biu_blend.
module biu_coord #(
   parameter int SRC_MAX_WIDTH  = 256,
   parameter int SRC_MAX_HEIGHT = 256,
   parameter int DST_MAX_DIM    = 4096,
   parameter int FRAC_BITS      = 16,
   localparam int CH = biu_pkg::half_width(SRC_MAX_WIDTH),
   localparam int RH = biu_pkg::half_width(SRC_MAX_HEIGHT)
) (
   input  logic                                   clock,
   input  logic                                   load,
   input  biu_pkg::req_word_type                  req_word,
   input  logic [biu_pkg::SIZE_W-1:0]             source_width,
   input  logic [biu_pkg::SIZE_W-1:0]             source_height,
   input  logic [biu_pkg::STEP_W-1:0]             step_x,
   input  logic [biu_pkg::STEP_W-1:0]             step_y,
   output logic                                   is_write,
   output logic                                   wr_ok,
   output logic [1:0]                             wr_bank,
   output logic [CH-1:0]                          wr_col,
   output logic [RH-1:0]                          wr_row,
   output logic [biu_pkg::PIXEL_W-1:0]            wr_data,
   output logic [CH-1:0]                          rd_col_even,
   output logic [CH-1:0]                          rd_col_odd,
   output logic [RH-1:0]                          rd_row_even,
   output logic [RH-1:0]                          rd_row_odd,
   output logic [FRAC_BITS-1:0]                   frac_x,
   output logic [FRAC_BITS-1:0]                   frac_y,
   output biu_pkg::tap_sel_type                   tap_sel,
   output logic [biu_pkg::DCOORD_W-1:0]           dst_col,
   output logic [biu_pkg::DCOORD_W-1:0]           dst_row
);

   localparam int CW    = $clog2(SRC_MAX_WIDTH);
   localparam int RW    = $clog2(SRC_MAX_HEIGHT);
   localparam int EXT_W = biu_pkg::COORD_EXT_W;
   localparam int DW    = biu_pkg::DCOORD_W;
   localparam int POS_W = biu_pkg::DCOORD_W + biu_pkg::STEP_W;
   localparam int IX_W  = POS_W - FRAC_BITS;
   localparam int CMP_W = (IX_W > EXT_W) ? IX_W : EXT_W;
   localparam logic [biu_pkg::DST_LIM_W-1:0] DST_LIM = biu_pkg::DST_LIM_W'(DST_MAX_DIM - 1);
   localparam logic [EXT_W-1:0] W_LIM = EXT_W'(SRC_MAX_WIDTH);
   localparam logic [EXT_W-1:0] H_LIM = EXT_W'(SRC_MAX_HEIGHT);

   function automatic logic [EXT_W-1:0] size_last(input logic [biu_pkg::SIZE_W-1:0] sz,
                                                  input logic [EXT_W-1:0] lim);
      logic [EXT_W-1:0] sz_e;
      sz_e = EXT_W'(sz);
      if (sz_e == '0) begin
         return '0;
      end else if (sz_e > lim) begin
         return lim - EXT_W'(1);
      end else begin
         return sz_e - EXT_W'(1);
      end
   endfunction

   function automatic logic [DW-1:0] dst_clamp(input logic [DW-1:0] c);
      if (biu_pkg::DST_LIM_W'(c) > DST_LIM) begin
         return DST_LIM[DW-1:0];
      end else begin
         return c;
      end
   endfunction

   biu_pkg::cmd_type                   kind_ff;
   logic [POS_W-1:0]                   posx_ff, posx_in;
   logic [POS_W-1:0]                   posy_ff, posy_in;
   logic [biu_pkg::SRC_COORD_W-1:0]    wcol_ff, wrow_ff;
   logic [biu_pkg::PIXEL_W-1:0]        wdata_ff;
   logic [DW-1:0]                      dcol_ff, drow_ff;

   logic [CMP_W-1:0] ix_e, iy_e;
   logic [EXT_W-1:0] w_last_e, h_last_e;
   logic [CW-1:0]    x0;
   logic [RW-1:0]    y0;
   logic             x_clamp, y_clamp;
   logic [EXT_W-1:0] x0_e, y0_e, x_even_e, y_even_e;
   logic [EXT_W-1:0] wcol_e, wrow_e;

   assign posx_in = POS_W'(dst_clamp(req_word.dst_col)) * POS_W'(step_x);
   assign posy_in = POS_W'(dst_clamp(req_word.dst_row)) * POS_W'(step_y);

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= req_word.cmd;
         posx_ff  <= posx_in;
         posy_ff  <= posy_in;
         wcol_ff  <= req_word.src_col;
         wrow_ff  <= req_word.src_row;
         wdata_ff <= {req_word.in_alpha, req_word.in_red, req_word.in_green, req_word.in_blue};
         dcol_ff  <= req_word.dst_col;
         drow_ff  <= req_word.dst_row;
      end
   end

   // neighbor rows and columns, clamped to the last valid one
   always_comb begin
      ix_e     = CMP_W'(posx_ff[POS_W-1:FRAC_BITS]);
      iy_e     = CMP_W'(posy_ff[POS_W-1:FRAC_BITS]);
      w_last_e = size_last(source_width, W_LIM);
      h_last_e = size_last(source_height, H_LIM);
      x_clamp  = ix_e >= CMP_W'(w_last_e);
      y_clamp  = iy_e >= CMP_W'(h_last_e);
      x0       = x_clamp ? w_last_e[CW-1:0] : ix_e[CW-1:0];
      y0       = y_clamp ? h_last_e[RW-1:0] : iy_e[RW-1:0];
      x0_e     = EXT_W'(x0);
      y0_e     = EXT_W'(y0);
      x_even_e = x0_e + EXT_W'(x0[0]);
      y_even_e = y0_e + EXT_W'(y0[0]);
   end

   assign rd_col_even = x_even_e[CH:1];
   assign rd_col_odd  = x0_e[CH:1];
   assign rd_row_even = y_even_e[RH:1];
   assign rd_row_odd  = y0_e[RH:1];

   assign frac_x          = posx_ff[FRAC_BITS-1:0];
   assign frac_y          = posy_ff[FRAC_BITS-1:0];
   assign tap_sel.x_par   = x0[0];
   assign tap_sel.y_par   = y0[0];
   assign tap_sel.x_clamp = x_clamp;
   assign tap_sel.y_clamp = y_clamp;
   assign dst_col         = dcol_ff;
   assign dst_row         = drow_ff;

   assign wcol_e   = EXT_W'(wcol_ff);
   assign wrow_e   = EXT_W'(wrow_ff);
   assign is_write = (kind_ff == biu_pkg::CMD_WRITE);
   assign wr_ok    = (wcol_e < W_LIM) && (wrow_e < H_LIM);
   assign wr_bank  = {wrow_ff[0], wcol_ff[0]};
   assign wr_col   = wcol_e[CH:1];
   assign wr_row   = wrow_e[RH:1];
   assign wr_data  = wdata_ff;

endmodule

// ----- rtl/core/biu_frame.sv -----
// Source frame store, four banks split by column and row parity.
// Uses biu_pkg; one write or one four-neighbor read per clock, read data registered.
module biu_frame #(
   parameter int COL_HALF_W = 7,
   parameter int ROW_HALF_W = 7
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [1:0]                          wr_bank,
   input  logic [COL_HALF_W-1:0]               wr_col,
   input  logic [ROW_HALF_W-1:0]               wr_row,
   input  logic [biu_pkg::PIXEL_W-1:0]         wr_data,
   input  logic                                rd_en,
   input  logic [COL_HALF_W-1:0]               rd_col_even,
   input  logic [COL_HALF_W-1:0]               rd_col_odd,
   input  logic [ROW_HALF_W-1:0]               rd_row_even,
   input  logic [ROW_HALF_W-1:0]               rd_row_odd,
   output logic [3:0][biu_pkg::PIXEL_W-1:0]    rd_data
);

   localparam int ADDR_W = COL_HALF_W + ROW_HALF_W;
   localparam int DEPTH  = 1 << ADDR_W;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [biu_pkg::PIXEL_W-1:0] mem [DEPTH];
      logic [biu_pkg::PIXEL_W-1:0] rd_data_ff;
      logic [ADDR_W-1:0]           waddr, raddr;

      // bank index is {row parity, column parity}
      assign waddr = {wr_row, wr_col};
      assign raddr = {(b / 2 == 1) ? rd_row_odd : rd_row_even,
                      (b % 2 == 1) ? rd_col_odd : rd_col_even};

      always_ff @(posedge clock) begin
         if (wr_en && wr_bank == 2'(b)) begin
            mem[waddr] <= wr_data;
         end
         if (rd_en) begin
            rd_data_ff <= mem[raddr];
         end
      end

      assign rd_data[b] = rd_data_ff;
   end

endmodule

// ----- rtl/core/biu_blend.sv -----
// Blend stages: horizontal lerp per channel, then vertical lerp and truncate.
// Uses biu_pkg; takes bank data from biu_frame and taps from biu_coord.
module biu_blend #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                load2,
   input  logic                                load3,
   input  logic                                load4,
   input  logic [3:0][biu_pkg::PIXEL_W-1:0]    rd_data,
   input  logic [FRAC_BITS-1:0]                frac_x,
   input  logic [FRAC_BITS-1:0]                frac_y,
   input  biu_pkg::tap_sel_type                tap_sel,
   input  logic [biu_pkg::DCOORD_W-1:0]        dst_col,
   input  logic [biu_pkg::DCOORD_W-1:0]        dst_row,
   output biu_pkg::rsp_word_type               rsp_word
);

   localparam int CW     = biu_pkg::CHAN_W;
   localparam int DW     = biu_pkg::DCOORD_W;
   localparam int MUL1_W = CW + FRAC_BITS + 1;
   localparam int TOP_W  = CW + FRAC_BITS;
   localparam int SUM_W  = TOP_W + FRAC_BITS + 1;
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [FRAC_BITS-1:0]    fx2_ff, fy2_ff, fy3_ff;
   biu_pkg::tap_sel_type    sel2_ff;
   logic [DW-1:0]           col2_ff, row2_ff, col3_ff, row3_ff;
   logic [3:0][TOP_W-1:0]   top_ff, top_in, bot_ff, bot_in;
   logic [3:0][CW-1:0]      chan_in;
   biu_pkg::rsp_word_type   rsp_ff, rsp_in;

   logic [1:0]              b00, b01, b10, b11;
   logic [FRAC_BITS:0]      wx0, wx1, wy0, wy1;

   always_ff @(posedge clock) begin
      if (load2) begin
         fx2_ff  <= frac_x;
         fy2_ff  <= frac_y;
         sel2_ff <= tap_sel;
         col2_ff <= dst_col;
         row2_ff <= dst_row;
      end
   end

   // right or lower neighbor falls back to the left or upper one at the edge
   assign b00 = {sel2_ff.y_par, sel2_ff.x_par};
   assign b01 = {sel2_ff.y_par, sel2_ff.x_par ^ !sel2_ff.x_clamp};
   assign b10 = {sel2_ff.y_par ^ !sel2_ff.y_clamp, sel2_ff.x_par};
   assign b11 = {sel2_ff.y_par ^ !sel2_ff.y_clamp, sel2_ff.x_par ^ !sel2_ff.x_clamp};

   assign wx1 = {1'b0, fx2_ff};
   assign wx0 = ONE - wx1;
   assign wy1 = {1'b0, fy3_ff};
   assign wy0 = ONE - wy1;

   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [CW-1:0]     p00, p01, p10, p11;
      logic [MUL1_W-1:0] top_full, bot_full;
      logic [SUM_W-1:0]  sum;

      assign p00 = rd_data[b00][CW*k +: CW];
      assign p01 = rd_data[b01][CW*k +: CW];
      assign p10 = rd_data[b10][CW*k +: CW];
      assign p11 = rd_data[b11][CW*k +: CW];

      assign top_full  = MUL1_W'(p00) * MUL1_W'(wx0) + MUL1_W'(p01) * MUL1_W'(wx1);
      assign bot_full  = MUL1_W'(p10) * MUL1_W'(wx0) + MUL1_W'(p11) * MUL1_W'(wx1);
      assign top_in[k] = top_full[TOP_W-1:0];
      assign bot_in[k] = bot_full[TOP_W-1:0];

      assign sum        = SUM_W'(top_ff[k]) * SUM_W'(wy0) + SUM_W'(bot_ff[k]) * SUM_W'(wy1);
      assign chan_in[k] = sum[2*FRAC_BITS +: CW];
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         top_ff  <= top_in;
         bot_ff  <= bot_in;
         fy3_ff  <= fy2_ff;
         col3_ff <= col2_ff;
         row3_ff <= row2_ff;
      end
   end

   always_comb begin
      rsp_in.out_blue  = chan_in[0];
      rsp_in.out_green = chan_in[1];
      rsp_in.out_red   = chan_in[2];
      rsp_in.out_alpha = chan_in[3];
      rsp_in.out_col   = col3_ff;
      rsp_in.out_row   = row3_ff;
   end

   always_ff @(posedge clock) begin
      if (load4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for bilinear_image_upscaler: a short directed script,
// then random phases under varied size and step settings. Depends on biu_pkg.
module testbench;

   localparam longint unsigned UNIT = 64'd65536;
   localparam int ITEM_TARGET = 560;
   localparam int DRAIN_CYCLES = 8;

   typedef enum logic {ROW_WORD, ROW_SETTING} row_kind_type;
   typedef enum logic [1:0] {
      STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY
   } stall_mode_type;

   typedef struct {
      row_kind_type          kind;
      biu_pkg::req_word_type word;
      bit                    typed;
      biu_pkg::rsp_word_type pixel;
      logic [8:0]            width;
      logic [8:0]            height;
      logic [16:0]           sx;
      logic [16:0]           sy;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   biu_pkg::req_word_type req_word;
   logic rsp_valid;
   logic rsp_stall;
   biu_pkg::rsp_word_type rsp_word;
   logic csr_wr_en;
   logic [biu_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [biu_pkg::CSR_DATA_W-1:0] csr_wdata;

   logic [31:0] frame_store [0:65535];
   bit frame_filled [0:65535];
   logic [8:0] width_reg = biu_pkg::SOURCE_WIDTH_RESET;
   logic [8:0] height_reg = biu_pkg::SOURCE_HEIGHT_RESET;
   logic [16:0] step_x_reg = biu_pkg::STEP_RESET;
   logic [16:0] step_y_reg = biu_pkg::STEP_RESET;

   biu_pkg::rsp_word_type pending_pixels [$];
   script_row_type script [$];
   int accepted_items = 0;
   int error_count = 0;
   int burst_left = 0;

   always #1 clock = ~clock;

   bilinear_image_upscaler u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   task automatic flag_error(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want, input string tag);
      if (got != want) flag_error($sformatf("%s %s: got %0d expected %0d", tag, name, got, want));
   endtask

   function automatic longint unsigned clamped_size(input logic [8:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return 64'(v);
   endfunction

   // source position of a destination pixel: fractions and the four tap addresses
   function automatic void locate(input logic [11:0] dcol, input logic [11:0] drow,
                                  output logic [15:0] fx, output logic [15:0] fy,
                                  output logic [3:0][15:0] taps);
      longint unsigned px, py, ix, iy, w, h, x0, x1, y0, y1;
      w = clamped_size(width_reg);
      h = clamped_size(height_reg);
      px = 64'(dcol) * 64'(step_x_reg);
      py = 64'(drow) * 64'(step_y_reg);
      ix = px >> 16;
      iy = py >> 16;
      fx = px[15:0];
      fy = py[15:0];
      x0 = (ix < w - 1) ? ix : w - 1;
      x1 = (ix + 1 < w - 1) ? ix + 1 : w - 1;
      y0 = (iy < h - 1) ? iy : h - 1;
      y1 = (iy + 1 < h - 1) ? iy + 1 : h - 1;
      taps[0] = {y0[7:0], x0[7:0]};
      taps[1] = {y0[7:0], x1[7:0]};
      taps[2] = {y1[7:0], x0[7:0]};
      taps[3] = {y1[7:0], x1[7:0]};
   endfunction

   function automatic biu_pkg::rsp_word_type blend_pixel(input logic [11:0] dcol,
                                                         input logic [11:0] drow);
      logic [15:0] fx, fy;
      logic [3:0][15:0] taps;
      logic [31:0] tap_px [4];
      longint unsigned top, bot, acc;
      logic [7:0] ch [4];
      biu_pkg::rsp_word_type r;
      locate(dcol, drow, fx, fy, taps);
      for (int k = 0; k < 4; k++) tap_px[k] = frame_store[taps[k]];
      for (int c = 0; c < 4; c++) begin
         top = tap_px[0][8*c +: 8] * (UNIT - fx) + tap_px[1][8*c +: 8] * fx;
         bot = tap_px[2][8*c +: 8] * (UNIT - fx) + tap_px[3][8*c +: 8] * fx;
         acc = top * (UNIT - fy) + bot * fy;
         ch[c] = 8'(acc >> 32);
      end
      r.out_blue = ch[0];
      r.out_green = ch[1];
      r.out_red = ch[2];
      r.out_alpha = ch[3];
      r.out_col = dcol;
      r.out_row = drow;
      return r;
   endfunction

   function automatic biu_pkg::req_word_type write_word(input logic [7:0] col,
                                                        input logic [7:0] row,
                                                        input logic [7:0] b, input logic [7:0] g,
                                                        input logic [7:0] r, input logic [7:0] a);
      biu_pkg::req_word_type w;
      w.cmd = biu_pkg::CMD_WRITE;
      w.src_col = col;
      w.src_row = row;
      w.in_blue = b;
      w.in_green = g;
      w.in_red = r;
      w.in_alpha = a;
      w.dst_col = 12'($urandom_range(0, 4095));
      w.dst_row = 12'($urandom_range(0, 4095));
      return w;
   endfunction

   function automatic biu_pkg::req_word_type request_word(input logic [11:0] col,
                                                          input logic [11:0] row);
      biu_pkg::req_word_type w;
      w = write_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      w.cmd = biu_pkg::CMD_REQUEST;
      w.dst_col = col;
      w.dst_row = row;
      return w;
   endfunction

   function automatic script_row_type blank_row(input row_kind_type kind);
      script_row_type s;
      s.kind = kind;
      s.word = '0;
      s.typed = 1'b0;
      s.pixel = '0;
      s.width = '0;
      s.height = '0;
      s.sx = '0;
      s.sy = '0;
      return s;
   endfunction

   function automatic void add_write(input logic [7:0] col, input logic [7:0] row, input logic [7:0] b,
                                     input logic [7:0] g, input logic [7:0] r, input logic [7:0] a);
      script_row_type s;
      s = blank_row(ROW_WORD);
      s.word = write_word(col, row, b, g, r, a);
      script.push_back(s);
   endfunction

   function automatic void add_request(input logic [11:0] col, input logic [11:0] row);
      script_row_type s;
      s = blank_row(ROW_WORD);
      s.word = request_word(col, row);
      script.push_back(s);
   endfunction

   function automatic void add_typed(input logic [11:0] col, input logic [11:0] row, input logic [7:0] b,
                                     input logic [7:0] g, input logic [7:0] r, input logic [7:0] a);
      script_row_type s;
      s = blank_row(ROW_WORD);
      s.word = request_word(col, row);
      s.typed = 1'b1;
      s.pixel.out_blue = b;
      s.pixel.out_green = g;
      s.pixel.out_red = r;
      s.pixel.out_alpha = a;
      s.pixel.out_col = col;
      s.pixel.out_row = row;
      script.push_back(s);
   endfunction

   function automatic void add_setting(input logic [8:0] w, input logic [8:0] h,
                                       input logic [16:0] sx, input logic [16:0] sy);
      script_row_type s;
      s = blank_row(ROW_SETTING);
      s.width = w;
      s.height = h;
      s.sx = sx;
      s.sy = sy;
      script.push_back(s);
   endfunction

   // entered and left at a falling edge
   task automatic send_word(input biu_pkg::req_word_type w, input bit typed,
                            input biu_pkg::rsp_word_type pixel);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accepted_items++;
      if (w.cmd == biu_pkg::CMD_WRITE) begin
         frame_store[{w.src_row, w.src_col}] = {w.in_alpha, w.in_red, w.in_green, w.in_blue};
         frame_filled[{w.src_row, w.src_col}] = 1'b1;
      end else begin
         pending_pixels.push_back(typed ? pixel : blend_pixel(w.dst_col, w.dst_row));
      end
      @(negedge clock);
   endtask

   // writes any tap that was never written, then asks for the pixel
   task automatic request_pixel(input logic [11:0] col, input logic [11:0] row);
      logic [15:0] fx, fy;
      logic [3:0][15:0] taps;
      locate(col, row, fx, fy, taps);
      for (int k = 0; k < 4; k++) begin
         if (!frame_filled[taps[k]])
            send_word(write_word(taps[k][7:0], taps[k][15:8], 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255))), 1'b0, '0);
      end
      send_word(request_word(col, row), 1'b0, '0);
   endtask

   function automatic logic [11:0] reach(input logic [8:0] size, input logic [16:0] step);
      longint unsigned lim;
      if (step == 0) return 12'($urandom_range(0, 4095));
      lim = clamped_size(size) * UNIT / step + 1;
      if (lim > 4095) lim = 4095;
      return 12'($urandom_range(0, lim));
   endfunction

   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [biu_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [biu_pkg::CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic [8:0] w, input logic [8:0] h,
                                input logic [16:0] sx, input logic [16:0] sy);
      write_csr(biu_pkg::CSR_SOURCE_WIDTH, biu_pkg::CSR_DATA_W'(w));
      write_csr(biu_pkg::CSR_SOURCE_HEIGHT, biu_pkg::CSR_DATA_W'(h));
      write_csr(biu_pkg::CSR_STEP_X, sx);
      write_csr(biu_pkg::CSR_STEP_Y, sy);
      csr_wr_en <= 1'b0;
      width_reg = w;
      height_reg = h;
      step_x_reg = sx;
      step_y_reg = sy;
   endtask

   function automatic logic [8:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 9'($urandom_range(1, 16));
      if (r < 70) return 9'd0;
      if (r < 80) return 9'd256;
      if (r < 90) return 9'($urandom_range(257, 511));
      return 9'($urandom_range(1, 255));
   endfunction

   function automatic logic [16:0] pick_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 17'd0;
      if (r < 35) return 17'd65536;
      if (r < 45) return 17'h1FFFF;
      if (r < 85) return 17'($urandom_range(1, 65535));
      return 17'($urandom_range(65537, 131071));
   endfunction

   always @(posedge clock) begin : rsp_check
      biu_pkg::rsp_word_type want;
      string tag;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            flag_error($sformatf("unexpected pixel (%0d,%0d)", rsp_word.out_col, rsp_word.out_row));
         end else begin
            want = pending_pixels.pop_front();
            tag = $sformatf("pixel (%0d,%0d)", want.out_col, want.out_row);
            check_field("blue", rsp_word.out_blue, want.out_blue, tag);
            check_field("green", rsp_word.out_green, want.out_green, tag);
            check_field("red", rsp_word.out_red, want.out_red, tag);
            check_field("alpha", rsp_word.out_alpha, want.out_alpha, tag);
            check_field("col", rsp_word.out_col, want.out_col, tag);
            check_field("row", rsp_word.out_row, want.out_row, tag);
         end
      end
   end

   initial begin : stall_pattern
      stall_mode_type mode;
      int left;
      int tick;
      bit held;
      rsp_stall = 1'b0;
      mode = STALL_NONE;
      left = 0;
      tick = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && accepted_items >= 250) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
         end else begin
            if (left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               left = $urandom_range(10, 120);
            end
            left--;
            tick++;
            case (mode)
               STALL_NONE: rsp_stall <= 1'b0;
               STALL_SPARSE: rsp_stall <= ($urandom_range(0, 99) < 30);
               STALL_PERIODIC: rsp_stall <= (tick % 4 == 3);
               default: rsp_stall <= ($urandom_range(0, 99) < 80);
            endcase
         end
      end
   end

   initial begin
      #1_000_000;
      $display("bilinear_image_upscaler regression: fail");
      $finish;
   end

   initial begin
      int phase;
      int phase_end;
      int r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_wr_en = 1'b0;
      csr_index = biu_pkg::CSR_SOURCE_WIDTH;
      csr_wdata = '0;

      // reset settings: 256 x 256, unit step
      add_write(0, 0, 8'h00, 8'hFF, 8'h00, 8'hFF);
      add_write(1, 0, 8'hFF, 8'h00, 8'hFF, 8'h00);
      add_write(0, 1, 8'h55, 8'hAA, 8'h55, 8'hAA);
      add_write(1, 1, 8'hAA, 8'h55, 8'hAA, 8'h55);
      add_typed(0, 0, 8'h00, 8'hFF, 8'h00, 8'hFF);
      add_write(255, 255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_typed(255, 255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_typed(4095, 4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_write(255, 0, 8'h01, 8'h02, 8'h04, 8'h08);
      add_write(255, 1, 8'h80, 8'h40, 8'h20, 8'h10);
      add_typed(4095, 0, 8'h01, 8'h02, 8'h04, 8'h08);
      add_typed(255, 0, 8'h01, 8'h02, 8'h04, 8'h08);
      // half steps blend the 2x2 corner
      add_setting(256, 256, 17'h08000, 17'h08000);
      add_request(1, 1);
      add_request(1, 0);
      add_request(0, 1);
      // zero step always lands on the origin
      add_setting(256, 256, 17'h00000, 17'h00000);
      add_typed(4095, 4095, 8'h00, 8'hFF, 8'h00, 8'hFF);
      add_typed(0, 4095, 8'h00, 8'hFF, 8'h00, 8'hFF);
      // zero size acts as one pixel
      add_setting(0, 0, 17'd65536, 17'd65536);
      add_typed(200, 100, 8'h00, 8'hFF, 8'h00, 8'hFF);
      // oversize saturates to the store size
      add_setting(511, 511, 17'd65536, 17'd65536);
      add_typed(255, 255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_write(0, 0, 8'h00, 8'h00, 8'h00, 8'h00);
      add_typed(0, 0, 8'h00, 8'h00, 8'h00, 8'h00);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_SETTING) begin
            settle();
            apply_setting(script[i].width, script[i].height, script[i].sx, script[i].sy);
         end else begin
            send_word(script[i].word, script[i].typed, script[i].pixel);
         end
      end

      phase = 0;
      while (accepted_items < ITEM_TARGET) begin
         settle();
         case (phase)
            0: apply_setting(4, 3, 17'h08000, 17'h05555);
            1: apply_setting(0, 511, 17'd65536, 17'd0);
            2: apply_setting(256, 1, 17'h1FFFF, 17'd65536);
            3: apply_setting(1, 256, 17'h04000, 17'h1FFFF);
            default: apply_setting(pick_size(), pick_size(), pick_step(), pick_step());
         endcase
         phase_end = accepted_items + $urandom_range(40, 90);
         while (accepted_items < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 15)
               send_word(write_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))),
                         1'b0, '0);
            else if (r < 25)
               request_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
            else
               request_pixel(reach(width_reg, step_x_reg), reach(height_reg, step_y_reg));
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("bilinear_image_upscaler regression: pass");
      else
         $display("bilinear_image_upscaler regression: fail");
      $finish;
   end

endmodule
